// ===== hdl/cot_pkg.sv =====
// Package with constants and shared types for the clock offset tracker.
package cot_pkg;

   localparam int PEER_COUNT = 8;
   localparam int PEER_IDX_W = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;

   localparam int STAMP_W = 31;
   localparam int LIMIT_W = 24;
   localparam int VALUE_W = 32;
   localparam int PEER_W  = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(60000);
   localparam logic signed [VALUE_W-1:0] DELAY_RESET = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] OFFSET_RESET = '0;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 96;

   typedef enum logic {
      OP_SAMPLE  = 1'b0,
      OP_CONVERT = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [PEER_W-1:0]   peer;
      logic                request_ok;
      logic                response_ok;
      logic [STAMP_W-1:0]  req_sent_time;
      logic [STAMP_W-1:0]  req_recv_time;
      logic [STAMP_W-1:0]  resp_sent_time;
      logic [STAMP_W-1:0]  resp_recv_time;
      logic [STAMP_W-1:0]  remote_stamp;
   } item_type;

   typedef struct packed {
      logic [STAMP_W-1:0]        local_stamp;
      logic                      entry_updated;
      logic signed [VALUE_W-1:0] best_delay;
      logic signed [VALUE_W-1:0] best_offset;
   } result_type;

   typedef struct packed {
      logic                      en;
      logic [PEER_IDX_W-1:0]     idx;
      logic signed [VALUE_W-1:0] delay;
      logic signed [VALUE_W-1:0] offset;
   } tbl_wr_type;

endpackage

// ===== hdl/cot_table.sv =====
// Per-peer table of best round-trip delay and clock offset, held in flip-flops.
module cot_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [cot_pkg::PEER_IDX_W-1:0]     rd_idx,
   output logic signed [cot_pkg::VALUE_W-1:0] rd_delay,
   output logic signed [cot_pkg::VALUE_W-1:0] rd_offset,
   input  cot_pkg::tbl_wr_type                tbl_wr
);

   logic signed [cot_pkg::VALUE_W-1:0] delay_ff  [cot_pkg::PEER_COUNT];
   logic signed [cot_pkg::VALUE_W-1:0] offset_ff [cot_pkg::PEER_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cot_pkg::PEER_COUNT; i++) begin
            delay_ff[i]  <= cot_pkg::DELAY_RESET;
            offset_ff[i] <= cot_pkg::OFFSET_RESET;
         end
      end else if (tbl_wr.en) begin
         delay_ff[tbl_wr.idx]  <= tbl_wr.delay;
         offset_ff[tbl_wr.idx] <= tbl_wr.offset;
      end
   end

   assign rd_delay  = delay_ff[rd_idx];
   assign rd_offset = offset_ff[rd_idx];

endmodule

// ===== hdl/cot_calc.sv =====
// Delay, offset and timestamp conversion logic for one registered transaction.
module cot_calc (
   input  cot_pkg::item_type                  item,
   input  logic                               fire,
   input  logic [cot_pkg::LIMIT_W-1:0]        resync_limit,
   output logic [cot_pkg::PEER_IDX_W-1:0]     rd_idx,
   input  logic signed [cot_pkg::VALUE_W-1:0] rd_delay,
   input  logic signed [cot_pkg::VALUE_W-1:0] rd_offset,
   output cot_pkg::tbl_wr_type                tbl_wr,
   output cot_pkg::result_type                result
);

   logic               peer_ok;
   logic signed [33:0] t1, t2, t3, t4, stamp, limit;
   logic signed [33:0] old_delay, old_offset;
   logic signed [33:0] delay_raw, sum, half, jump_s, jump;
   logic signed [33:0] diff, shifted;
   logic signed [31:0] new_delay, new_offset;
   logic [cot_pkg::STAMP_W-1:0] converted;
   logic               update, keep;

   always_comb begin
      peer_ok = (item.peer != '0) && (int'(item.peer) <= cot_pkg::PEER_COUNT);
      rd_idx  = cot_pkg::PEER_IDX_W'(item.peer - cot_pkg::PEER_W'(1));

      t1    = signed'({3'b000, item.req_sent_time});
      t2    = signed'({3'b000, item.req_recv_time});
      t3    = signed'({3'b000, item.resp_sent_time});
      t4    = signed'({3'b000, item.resp_recv_time});
      stamp = signed'({3'b000, item.remote_stamp});
      limit = signed'({10'b0, resync_limit});
      old_delay  = 34'(rd_delay);
      old_offset = 34'(rd_offset);

      delay_raw = (t4 - t1) - (t3 - t2);
      if (delay_raw > 34'sh0_7FFF_FFFF) begin
         new_delay = 32'sh7FFF_FFFF;
      end else if (delay_raw < -34'sh0_8000_0000) begin
         new_delay = -32'sh8000_0000;
      end else begin
         new_delay = delay_raw[31:0];
      end

      // Halve with truncation toward zero.
      sum        = (t2 - t1) + (t3 - t4);
      half       = (sum + ((sum[33] && sum[0]) ? 34'sd1 : 34'sd0)) >>> 1;
      new_offset = half[31:0];

      jump_s = old_offset - 34'(new_offset);
      jump   = jump_s[33] ? -jump_s : jump_s;

      update = (item.opcode == cot_pkg::OP_SAMPLE) && peer_ok && item.request_ok
               && item.response_ok && ((34'(new_delay) < old_delay) || (jump > limit));

      diff    = old_offset[33] ? -old_offset : old_offset;
      keep    = (diff < limit) && (diff <= old_delay);
      shifted = stamp - old_offset;
      if (shifted[33]) begin
         converted = '0;
      end else if (shifted > 34'sh0_7FFF_FFFF) begin
         converted = '1;
      end else begin
         converted = shifted[cot_pkg::STAMP_W-1:0];
      end

      tbl_wr.en     = update && fire;
      tbl_wr.idx    = rd_idx;
      tbl_wr.delay  = new_delay;
      tbl_wr.offset = new_offset;

      if (item.opcode == cot_pkg::OP_SAMPLE) begin
         result.local_stamp = '0;
      end else if (!peer_ok || item.remote_stamp == '0 || keep) begin
         result.local_stamp = item.remote_stamp;
      end else begin
         result.local_stamp = converted;
      end
      result.entry_updated = update;
      if (!peer_ok) begin
         result.best_delay  = cot_pkg::DELAY_RESET;
         result.best_offset = cot_pkg::OFFSET_RESET;
      end else if (update) begin
         result.best_delay  = new_delay;
         result.best_offset = new_offset;
      end else begin
         result.best_delay  = rd_delay;
         result.best_offset = rd_offset;
      end
   end

endmodule

// ===== hdl/clock_offset_tracker.sv =====
// Each taken request is held in the input register; its result is then loaded into the result register.
// Throughput: one transaction per cycle unless a held result stalls it, bounded by the single
// table read-modify-write between the input register and the result register.
// Reset: synchronous; clears both pipeline stages, sets every delay entry to the largest
// positive value, every offset entry to zero and the resync limit to 60000.
module clock_offset_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [cot_pkg::LIMIT_W-1:0]      csr_wr_data,   // resync_limit
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // peer[3:0], request_ok[4], response_ok[5], req_sent_time[36:6],
   // req_recv_time[67:37], resp_sent_time[98:68], resp_recv_time[129:99],
   // remote_stamp[160:130], zero fill[167:161]
   input  logic [cot_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,     // opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // local_stamp[30:0], entry_updated[31], best_delay[63:32], best_offset[95:64]
   output logic [cot_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic [cot_pkg::LIMIT_W-1:0] limit_ff;
   logic                        in_valid_ff, in_valid_in;
   cot_pkg::item_type           item_ff, item_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   cot_pkg::result_type         rsp_ff, result;
   logic                        advance;
   logic [cot_pkg::PEER_IDX_W-1:0]     rd_idx;
   logic signed [cot_pkg::VALUE_W-1:0] rd_delay, rd_offset;
   cot_pkg::tbl_wr_type                tbl_wr;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      item_in.opcode         = cot_pkg::opcode_type'(req_tuser);
      item_in.peer           = req_tdata[3:0];
      item_in.request_ok     = req_tdata[4];
      item_in.response_ok    = req_tdata[5];
      item_in.req_sent_time  = req_tdata[36:6];
      item_in.req_recv_time  = req_tdata[67:37];
      item_in.resp_sent_time = req_tdata[98:68];
      item_in.resp_recv_time = req_tdata[129:99];
      item_in.remote_stamp   = req_tdata[160:130];

      in_valid_in = req_tvalid || (in_valid_ff && !advance);
      if (!req_tready) begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= cot_pkg::LIMIT_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   cot_calc u_calc (
      .item         (item_ff),
      .fire         (advance),
      .resync_limit (limit_ff),
      .rd_idx       (rd_idx),
      .rd_delay     (rd_delay),
      .rd_offset    (rd_offset),
      .tbl_wr       (tbl_wr),
      .result       (result)
   );

   cot_table u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (rd_idx),
      .rd_delay  (rd_delay),
      .rd_offset (rd_offset),
      .tbl_wr    (tbl_wr)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.best_offset, rsp_ff.best_delay,
                        rsp_ff.entry_updated, rsp_ff.local_stamp};

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("Request side stalled without a blocked result.");

   a_write_on_move : assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |-> (advance && result.entry_updated))
      else $error("Table written without a transaction moving forward.");

   a_update_loads : assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |=> (rsp_tvalid && rsp_tdata[31]))
      else $error("Table update not reported in the result.");

endmodule
